@@ design/odt_pkg.sv @@
// Package for the ordered-dither tinting pipeline: sizes, dither and tint tables,
// and the structs passed between the top level and the quantiser.
// Depends on nothing; imported by the quantiser, the top level and the testbench.
`timescale 1ns / 1ps

package odt_pkg;

    // Largest supported frame geometry
    localparam int ODT_MAX_LINE_WIDTH   = 4096;
    localparam int ODT_MAX_FRAME_HEIGHT = 4096;

    // Configuration registers
    localparam int ODT_CFG_WIDTH = 13;
    localparam int ODT_CFG_IDX_W = 1;
    localparam logic [ODT_CFG_IDX_W-1:0] ODT_REG_LINE_WIDTH   = 1'd0;
    localparam logic [ODT_CFG_IDX_W-1:0] ODT_REG_FRAME_HEIGHT = 1'd1;
    localparam logic [ODT_CFG_WIDTH-1:0] ODT_LINE_WIDTH_RST   = 13'd640;
    localparam logic [ODT_CFG_WIDTH-1:0] ODT_FRAME_HEIGHT_RST = 13'd480;

    // Luma weights, sum of weights is 256
    localparam logic [7:0] ODT_LUMA_R = 8'd77;
    localparam logic [7:0] ODT_LUMA_G = 8'd150;
    localparam logic [7:0] ODT_LUMA_B = 8'd29;

    // Dither offset step and level thresholds on the sixteenfold luma scale
    // (one level is 1360, rounding half away from zero puts the edges at 680 + n*1360)
    localparam logic signed [13:0] ODT_DITHER_STEP = 14'sd85;
    localparam logic signed [13:0] ODT_T_LEVEL1    = 14'sd680;
    localparam logic signed [13:0] ODT_T_LEVEL2    = 14'sd2040;
    localparam logic signed [13:0] ODT_T_LEVEL3    = 14'sd3400;

    // Bayer 4x4 matrix minus 8, indexed by {row[1:0], column[1:0]}
    localparam logic signed [4:0] ODT_BAYER [16] = '{
        -5'sd8,  5'sd0, -5'sd6,  5'sd2,
         5'sd4, -5'sd4,  5'sd6, -5'sd2,
        -5'sd5,  5'sd3, -5'sd7,  5'sd1,
         5'sd7, -5'sd1,  5'sd5, -5'sd3
    };

    // Output colour per level
    localparam logic [7:0] ODT_TINT_RED   [4] = '{8'd0, 8'd85, 8'd170, 8'd255};
    localparam logic [7:0] ODT_TINT_GREEN [4] = '{8'd0, 8'd72, 8'd144, 8'd216};
    localparam logic [7:0] ODT_TINT_BLUE  [4] = '{8'd0, 8'd51, 8'd102, 8'd153};

    // Pixel held in the input register
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [1:0] row_phase;
        logic [1:0] col_phase;
        logic       eof;
    } odt_stage_t;

    // Pixel held in the result register
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       eof;
    } odt_result_t;

endpackage

@@ design/odt_pix_in_if.sv @@
// Input pixel channel: valid/ready handshake with an RGBA payload.
// Stands alone; used by the top level and the source that feeds it.
`timescale 1ns / 1ps

interface odt_pix_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

@@ design/odt_pix_out_if.sv @@
// Output pixel channel: valid/ready handshake with the tinted RGBA payload.
// Stands alone; used by the top level and the sink that drains it.
`timescale 1ns / 1ps

interface odt_pix_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       end_of_frame;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, end_of_frame,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, end_of_frame,
                    output ready);
endinterface

@@ design/ordered_dither_tinted_pixel.sv @@
// Ordered-dither tinting stage for an RGBA pixel stream.
// Pixels enter on pix_in in raster order and leave on pix_out, one result per
// transaction, in the same order. Each result carries red 85*level, a warm green
// and blue tint of that level, the source alpha, and end_of_frame on the last
// pixel of each frame. The column and row position select a 4x4 Bayer offset.
// line_width and frame_height are set through cfg_we/cfg_index/cfg_data; the user
// must write them only while the stream is idle; the block does not enforce it.
// 0 acts as 1 and values above the maximum act as the maximum. Two registers: an
// input register, then a result register; a pixel leaves the input register
// once the result register is free. Throughput: one pixel per clock while pix_out
// does not stall, set by the single quantiser between the two registers.
// When pix_out stalls, the result register holds and the input register keeps
// accepting until both are full, so pix_in.ready falls only once two pixels wait.
// Reset (rst_n low, asynchronous) empties both registers, clears the column and
// row counters and loads line_width 640 and frame_height 480.
`timescale 1ns / 1ps

module ordered_dither_tinted_pixel
    import odt_pkg::*;
#(
    parameter int MAX_LINE_WIDTH   = ODT_MAX_LINE_WIDTH,
    parameter int MAX_FRAME_HEIGHT = ODT_MAX_FRAME_HEIGHT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    odt_pix_in_if.sink               pix_in,
    odt_pix_out_if.source            pix_out,
    input  logic                     cfg_we,
    input  logic [ODT_CFG_IDX_W-1:0] cfg_index,
    input  logic [ODT_CFG_WIDTH-1:0] cfg_data
);

    // Counter and size widths
    localparam int CW  = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
    localparam int RW  = (MAX_FRAME_HEIGHT > 1) ? $clog2(MAX_FRAME_HEIGHT) : 1;
    localparam int SWC = ((CW > ODT_CFG_WIDTH) ? CW : ODT_CFG_WIDTH) + 1;
    localparam int SWR = ((RW > ODT_CFG_WIDTH) ? RW : ODT_CFG_WIDTH) + 1;
    localparam logic [SWC-1:0] MAX_W = SWC'(MAX_LINE_WIDTH);
    localparam logic [SWR-1:0] MAX_H = SWR'(MAX_FRAME_HEIGHT);

    logic [ODT_CFG_WIDTH-1:0] line_width_reg, line_width_next;
    logic [ODT_CFG_WIDTH-1:0] frame_height_reg, frame_height_next;
    logic [CW-1:0]            col_reg, col_next;
    logic [RW-1:0]            row_reg, row_next;
    logic                     s1_valid_reg, s1_valid_next;
    odt_stage_t               s1_data_reg, s1_data_next;
    logic                     out_valid_reg, out_valid_next;
    odt_result_t              out_data_reg, out_data_next;

    logic [SWC-1:0] width_eff;
    logic [SWR-1:0] height_eff;
    logic           last_col;
    logic           last_row;
    logic           in_eof;
    logic           in_accept;
    logic           out_free;
    odt_result_t    quant_result;

    // Handshake: the result register frees when empty or taken
    assign out_free     = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !s1_valid_reg || out_free;
    assign in_accept    = pix_in.valid && pix_in.ready;

    // Write the configuration registers
    always_comb
    begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ODT_REG_LINE_WIDTH:   line_width_next   = cfg_data;
                ODT_REG_FRAME_HEIGHT: frame_height_next = cfg_data;
                default:              ;
            endcase
        end
    end

    // Clamp the frame size to 1..maximum
    always_comb
    begin
        if (line_width_reg == '0)
            width_eff = SWC'(1);
        else if (SWC'(line_width_reg) > MAX_W)
            width_eff = MAX_W;
        else
            width_eff = SWC'(line_width_reg);

        if (frame_height_reg == '0)
            height_eff = SWR'(1);
        else if (SWR'(frame_height_reg) > MAX_H)
            height_eff = MAX_H;
        else
            height_eff = SWR'(frame_height_reg);
    end

    // Detect the frame edges and advance the raster position on each transaction
    assign last_col = (SWC'(col_reg) + SWC'(1)) >= width_eff;
    assign last_row = (SWR'(row_reg) + SWR'(1)) >= height_eff;
    assign in_eof   = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Load the input register
    always_comb
    begin
        s1_data_next  = s1_data_reg;
        s1_valid_next = s1_valid_reg && !out_free;
        if (in_accept)
        begin
            s1_valid_next          = 1'b1;
            s1_data_next.red       = pix_in.red_in;
            s1_data_next.green     = pix_in.green_in;
            s1_data_next.blue      = pix_in.blue_in;
            s1_data_next.alpha     = pix_in.alpha_in;
            s1_data_next.row_phase = row_reg[1:0];
            s1_data_next.col_phase = col_reg[1:0];
            s1_data_next.eof       = in_eof;
        end
    end

    odt_quant u_quant
    (
        .stage  (s1_data_reg),
        .result (quant_result)
    );

    // Load the result register when it frees
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            out_data_next  = quant_result;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg   <= ODT_LINE_WIDTH_RST;
            frame_height_reg <= ODT_FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

    // Drive the output channel
    assign pix_out.valid        = out_valid_reg;
    assign pix_out.red_out      = out_data_reg.red;
    assign pix_out.green_out    = out_data_reg.green;
    assign pix_out.blue_out     = out_data_reg.blue;
    assign pix_out.alpha_out    = out_data_reg.alpha;
    assign pix_out.end_of_frame = out_data_reg.eof;

    // The last pixel of a frame returns the raster position to the origin
    ap_eof_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && in_eof |=> col_reg == '0 && row_reg == '0)
        else $error("raster position not cleared after end of frame");

    // A pending pixel moves into a free result register
    ap_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free |=> out_valid_reg)
        else $error("pending pixel lost on its way to the result register");

    // Both registers full and stalled: no new transaction
    ap_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !pix_out.ready |-> !pix_in.ready)
        else $error("input accepted while the pipeline is full");

    // Level zero gives black in every colour channel
    ap_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.red == 8'd0 |->
            out_data_reg.green == 8'd0 && out_data_reg.blue == 8'd0)
        else $error("tint inconsistent with level zero");

endmodule

@@ design/odt_quant.sv @@
// Luma, Bayer dither and four-level tint for one registered pixel.
// Depends on odt_pkg for the tables, thresholds and stage structs.
`timescale 1ns / 1ps

module odt_quant
    import odt_pkg::*;
(
    input  odt_stage_t  stage,
    output odt_result_t result
);

    logic [15:0]        luma_sum;
    logic [7:0]         luma;
    logic signed [13:0] offset;
    logic signed [13:0] level_t;
    logic [1:0]         level;

    // Weighted luma, weights sum to 256
    assign luma_sum = 16'(ODT_LUMA_R) * 16'(stage.red)
                    + 16'(ODT_LUMA_G) * 16'(stage.green)
                    + 16'(ODT_LUMA_B) * 16'(stage.blue);
    assign luma     = luma_sum[15:8];

    // Add the dither offset on the sixteenfold scale
    assign offset  = 14'(ODT_BAYER[{stage.row_phase, stage.col_phase}]) * ODT_DITHER_STEP;
    assign level_t = $signed({2'b00, luma, 4'b0000}) + offset;

    // Round to the nearest level; negative values fall below every threshold
    always_comb
    begin
        if (level_t >= ODT_T_LEVEL3)
            level = 2'd3;
        else if (level_t >= ODT_T_LEVEL2)
            level = 2'd2;
        else if (level_t >= ODT_T_LEVEL1)
            level = 2'd1;
        else
            level = 2'd0;
    end

    // Map the level to the tint and pass alpha and frame flag through
    assign result.red   = ODT_TINT_RED[level];
    assign result.green = ODT_TINT_GREEN[level];
    assign result.blue  = ODT_TINT_BLUE[level];
    assign result.alpha = stage.alpha;
    assign result.eof   = stage.eof;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the ordered-dither tinting stage.
// Drives RGBA pixels through the odt_pix_in_if / odt_pix_out_if channels and
// compares every result with an in-bench model; needs odt_pkg and both interfaces.
`timescale 1ns / 1ps

module tb_top
    import odt_pkg::*;
();

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [ODT_CFG_IDX_W-1:0] cfg_index;
    logic [ODT_CFG_WIDTH-1:0] cfg_data;

    odt_pix_in_if  pix_in_bus ();
    odt_pix_out_if pix_out_bus ();

    ordered_dither_tinted_pixel dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in_bus),
        .pix_out   (pix_out_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: programmed geometry and raster position
    logic [ODT_CFG_WIDTH-1:0] line_width_setting   = ODT_LINE_WIDTH_RST;
    logic [ODT_CFG_WIDTH-1:0] frame_height_setting = ODT_FRAME_HEIGHT_RST;
    int unsigned              column_pos = 0;
    int unsigned              row_pos    = 0;

    // Tinted pixels still owed by the block, oldest first
    odt_result_t tinted_q [$];

    int error_count     = 0;
    int pixel_count     = 0;
    int frame_end_count = 0;
    int cfg_write_count = 0;
    int src_gap_pct     = 0;
    int sink_stall_pct  = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    // Bayer 4x4 entry minus 8 at the given raster phase
    function automatic int dither_offset(input logic [1:0] row, input logic [1:0] col);
        case ({row, col})
            4'd0:  return -8;
            4'd1:  return 0;
            4'd2:  return -6;
            4'd3:  return 2;
            4'd4:  return 4;
            4'd5:  return -4;
            4'd6:  return 6;
            4'd7:  return -2;
            4'd8:  return -5;
            4'd9:  return 3;
            4'd10: return -7;
            4'd11: return 1;
            4'd12: return 7;
            4'd13: return -1;
            4'd14: return 5;
            4'd15: return -3;
            default: return 0;
        endcase
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int unsigned clamp_size(input logic [ODT_CFG_WIDTH-1:0] setting,
                                               input int unsigned max_size);
        if (setting == '0)
            return 1;
        if (setting > max_size)
            return max_size;
        return setting;
    endfunction

    // Quantise one pixel at the current position, then advance the raster
    function automatic odt_result_t tint_next_pixel(input rgba_t px);
        odt_result_t res;
        int          luma;
        int          dithered;
        int          level;
        int unsigned w;
        int unsigned h;
        logic        last_col;
        logic        last_row;

        luma     = (77 * int'(px.red) + 150 * int'(px.green) + 29 * int'(px.blue)) >> 8;
        dithered = 16 * luma + 85 * dither_offset(row_pos[1:0], column_pos[1:0]);
        if (dithered < 0)
            level = 0;
        else
        begin
            level = (dithered + 680) / 1360;
            if (level > 3)
                level = 3;
        end

        w        = clamp_size(line_width_setting, ODT_MAX_LINE_WIDTH);
        h        = clamp_size(frame_height_setting, ODT_MAX_FRAME_HEIGHT);
        last_col = (column_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);

        res.red   = 8'(85 * level);
        res.green = 8'(72 * level);
        res.blue  = 8'(51 * level);
        res.alpha = px.alpha;
        res.eof   = last_col && last_row;
        if (res.eof)
            frame_end_count++;

        if (last_col)
        begin
            column_pos = 0;
            row_pos    = last_row ? 0 : row_pos + 1;
        end
        else
            column_pos = column_pos + 1;
        return res;
    endfunction

    // Random pixel, biased now and then towards greys and saturated channels
    function automatic rgba_t random_pixel();
        rgba_t px;

        px = rgba_t'($urandom);
        case ($urandom_range(9))
            0:
            begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1:
            begin
                px.red   = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                px.green = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                px.blue  = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                px.alpha = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return px;
    endfunction

    // Offer one pixel, holding it until the block takes the transaction
    task automatic push_pixel(input rgba_t px);
        while ($urandom_range(99) < src_gap_pct)
        begin
            pix_in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in_bus.valid    <= 1'b1;
        pix_in_bus.red_in   <= px.red;
        pix_in_bus.green_in <= px.green;
        pix_in_bus.blue_in  <= px.blue;
        pix_in_bus.alpha_in <= px.alpha;
        @(posedge clk);
        while (!pix_in_bus.ready)
            @(posedge clk);
        tinted_q.push_back(tint_next_pixel(px));
        pixel_count++;
    endtask

    // Drop valid and wait until every owed pixel has come out
    task automatic drain_stream();
        pix_in_bus.valid <= 1'b0;
        while (tinted_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write one register once the stream is idle
    task automatic write_setting(input logic [ODT_CFG_IDX_W-1:0] index,
                                 input logic [ODT_CFG_WIDTH-1:0] value);
        drain_stream();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == ODT_REG_LINE_WIDTH)
            line_width_setting = value;
        else
            frame_height_setting = value;
        cfg_write_count++;
    endtask

    task automatic set_geometry(input logic [ODT_CFG_WIDTH-1:0] w,
                                input logic [ODT_CFG_WIDTH-1:0] h);
        write_setting(ODT_REG_LINE_WIDTH, w);
        write_setting(ODT_REG_FRAME_HEIGHT, h);
    endtask

    // Extremes of every channel at the reset geometry; a mid grey on the
    // first Bayer cell lands exactly on a rounding edge
    task automatic test_reset_defaults();
        push_pixel({8'd85, 8'd85, 8'd85, 8'd0});
        push_pixel({8'd0, 8'd0, 8'd0, 8'd255});
        push_pixel({8'd255, 8'd255, 8'd255, 8'd0});
        push_pixel({8'd255, 8'd0, 8'd0, 8'h55});
        push_pixel({8'd0, 8'd255, 8'd0, 8'hAA});
        push_pixel({8'd0, 8'd0, 8'd255, 8'd1});
        push_pixel({8'd255, 8'd0, 8'd255, 8'd128});
        push_pixel({8'd0, 8'd255, 8'd255, 8'd127});
        push_pixel({8'd42, 8'd42, 8'd42, 8'd7});
        push_pixel({8'd43, 8'd43, 8'd43, 8'd8});
        push_pixel({8'd127, 8'd127, 8'd127, 8'd9});
        push_pixel({8'd128, 8'd128, 8'd128, 8'd10});
        push_pixel({8'd170, 8'd170, 8'd170, 8'd11});
        push_pixel({8'd212, 8'd212, 8'd212, 8'd12});
        push_pixel({8'd213, 8'd213, 8'd213, 8'd13});
        push_pixel({8'd1, 8'd1, 8'd1, 8'd254});
        push_pixel({8'd254, 8'd254, 8'd254, 8'd2});
        push_pixel({8'hAA, 8'h55, 8'hAA, 8'h55});
        push_pixel({8'h55, 8'hAA, 8'h55, 8'hAA});
    endtask

    // Zero width and height behave as one: every pixel ends a frame; then height 3
    task automatic test_degenerate_sizes();
        set_geometry(13'd0, 13'd0);
        repeat (3) push_pixel(random_pixel());
        write_setting(ODT_REG_FRAME_HEIGHT, 13'd3);
        repeat (4) push_pixel(random_pixel());
    endtask

    // Shrink width and then height while the counters sit beyond the new edge
    task automatic test_shrink_mid_frame();
        set_geometry(13'd1, 13'd1);
        push_pixel(random_pixel());
        set_geometry(13'd12, 13'd6);
        repeat (7) push_pixel(random_pixel());
        write_setting(ODT_REG_LINE_WIDTH, 13'd3);
        repeat (10) push_pixel(random_pixel());
        write_setting(ODT_REG_FRAME_HEIGHT, 13'd2);
        repeat (8) push_pixel(random_pixel());
    endtask

    // Mostly whole small frames with random content; now and then odd or
    // huge geometry and truncated frames
    task automatic test_random_frames(input int budget);
        int          sent;
        int unsigned w;
        int unsigned h;
        int unsigned frame_len;
        int unsigned which;

        sent = 0;
        while (sent < budget)
        begin
            case ($urandom_range(19))
                0:       w = 0;
                1:       w = $urandom_range(8191);
                2:       w = $urandom_range(40, 9);
                default: w = $urandom_range(8, 1);
            endcase
            case ($urandom_range(19))
                0:       h = 0;
                1:       h = $urandom_range(8191);
                default: h = $urandom_range(6, 1);
            endcase
            which = $urandom_range(7);
            if (which == 1 || which >= 3)
                write_setting(ODT_REG_LINE_WIDTH, w[ODT_CFG_WIDTH-1:0]);
            if (which >= 2)
                write_setting(ODT_REG_FRAME_HEIGHT, h[ODT_CFG_WIDTH-1:0]);

            frame_len = clamp_size(line_width_setting, ODT_MAX_LINE_WIDTH) *
                        clamp_size(frame_height_setting, ODT_MAX_FRAME_HEIGHT);
            if (frame_len > 60 || $urandom_range(9) == 0)
                frame_len = $urandom_range(30, 1);
            repeat (frame_len) push_pixel(random_pixel());
            sent += frame_len;
        end
    endtask

    // Short runs from the origin at oversized width, then height; then the maximum
    task automatic test_oversized_geometry();
        set_geometry(13'd1, 13'd1);
        push_pixel(random_pixel());
        set_geometry(13'd8191, 13'd1);
        repeat (40) push_pixel(random_pixel());
        set_geometry(13'd1, 13'd1);
        push_pixel(random_pixel());
        set_geometry(13'd1, 13'd4097);
        repeat (40) push_pixel(random_pixel());
        set_geometry(13'd4096, 13'd4096);
        repeat (20) push_pixel(random_pixel());
    endtask

    // Result checker: every output transaction against the oldest expectation
    initial
    begin
        odt_result_t want;

        pix_out_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_out_bus.valid && pix_out_bus.ready)
            begin
                if (tinted_q.size() == 0)
                begin
                    $error("unexpected output transaction: nothing outstanding");
                    error_count++;
                end
                else
                begin
                    want = tinted_q.pop_front();
                    if (pix_out_bus.red_out !== want.red)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red,
                               pix_out_bus.red_out);
                        error_count++;
                    end
                    if (pix_out_bus.green_out !== want.green)
                    begin
                        $error("green_out: expected %0d, got %0d", want.green,
                               pix_out_bus.green_out);
                        error_count++;
                    end
                    if (pix_out_bus.blue_out !== want.blue)
                    begin
                        $error("blue_out: expected %0d, got %0d", want.blue,
                               pix_out_bus.blue_out);
                        error_count++;
                    end
                    if (pix_out_bus.alpha_out !== want.alpha)
                    begin
                        $error("alpha_out: expected %0d, got %0d", want.alpha,
                               pix_out_bus.alpha_out);
                        error_count++;
                    end
                    if (pix_out_bus.end_of_frame !== want.eof)
                    begin
                        $error("end_of_frame: expected %0d, got %0d", want.eof,
                               pix_out_bus.end_of_frame);
                        error_count++;
                    end
                end
            end
            pix_out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Test sequence
    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        pix_in_bus.valid    = 1'b0;
        pix_in_bus.red_in   = '0;
        pix_in_bus.green_in = '0;
        pix_in_bus.blue_in  = '0;
        pix_in_bus.alpha_in = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Mostly busy source, heavily stalled sink
        src_gap_pct    = 11;
        sink_stall_pct = 81;
        test_reset_defaults();
        test_degenerate_sizes();
        test_shrink_mid_frame();
        test_random_frames(450);

        // Bursty source, mostly ready sink
        src_gap_pct    = 81;
        sink_stall_pct = 11;
        test_random_frames(450);

        // Full rate both ways
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        test_random_frames(450);
        test_oversized_geometry();

        drain_stream();
        repeat (10) @(posedge clk);
        $display("covered %0d pixels, %0d frame ends and %0d register writes,",
                 pixel_count, frame_end_count, cfg_write_count);
        $display("geometry from 0 to 8191 including mid-frame shrinks and stalls both ways");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/odt_pkg.sv
design/odt_pix_in_if.sv
design/odt_pix_out_if.sv
design/odt_quant.sv
design/ordered_dither_tinted_pixel.sv
tb/tb_top.sv
